/* rtl/core/cpu8_pkg.sv */
package cpu8_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 16;

    typedef logic [CpW-1:0] t_cp;

    // encoded character: up to three bytes, lead byte first, plus count
    typedef struct packed {
        logic [ByteW-1:0] b0;
        logic [ByteW-1:0] b1;
        logic [ByteW-1:0] b2;
        logic [1:0]       cnt;   // 0 means no output
    } t_enc;

    localparam logic [1:0] CntNone  = 2'd0;
    localparam logic [1:0] CntOne   = 2'd1;
    localparam logic [1:0] CntTwo   = 2'd2;
    localparam logic [1:0] CntThree = 2'd3;

    function automatic t_cp cp437_lookup(input logic [7:0] b);
        t_cp r;
        begin
            r = {8'h00, b};
            case (b)
                8'h00: r = 16'h0000; 8'h01: r = 16'h263A; 8'h02: r = 16'h263B;
                8'h03: r = 16'h2665; 8'h04: r = 16'h2666; 8'h05: r = 16'h2663;
                8'h06: r = 16'h2660; 8'h07: r = 16'h2022; 8'h08: r = 16'h25D8;
                8'h09: r = 16'h25CB; 8'h0A: r = 16'h25D9; 8'h0B: r = 16'h2642;
                8'h0C: r = 16'h2640; 8'h0D: r = 16'h266A; 8'h0E: r = 16'h266B;
                8'h0F: r = 16'h263C; 8'h10: r = 16'h25BA; 8'h11: r = 16'h25C4;
                8'h12: r = 16'h2195; 8'h13: r = 16'h203C; 8'h14: r = 16'h00B6;
                8'h15: r = 16'h00A7; 8'h16: r = 16'h25AC; 8'h17: r = 16'h21A8;
                8'h18: r = 16'h2191; 8'h19: r = 16'h2193; 8'h1A: r = 16'h2192;
                8'h1B: r = 16'h2190; 8'h1C: r = 16'h221F; 8'h1D: r = 16'h2194;
                8'h1E: r = 16'h25B2; 8'h1F: r = 16'h25BC; 8'h7F: r = 16'h2302;
                8'h80: r = 16'h00C7; 8'h81: r = 16'h00FC; 8'h82: r = 16'h00E9;
                8'h83: r = 16'h00E2; 8'h84: r = 16'h00E4; 8'h85: r = 16'h00E0;
                8'h86: r = 16'h00E5; 8'h87: r = 16'h00E7; 8'h88: r = 16'h00EA;
                8'h89: r = 16'h00EB; 8'h8A: r = 16'h00E8; 8'h8B: r = 16'h00EF;
                8'h8C: r = 16'h00EE; 8'h8D: r = 16'h00EC; 8'h8E: r = 16'h00C4;
                8'h8F: r = 16'h00C5; 8'h90: r = 16'h00C9; 8'h91: r = 16'h00E6;
                8'h92: r = 16'h00C6; 8'h93: r = 16'h00F4; 8'h94: r = 16'h00F6;
                8'h95: r = 16'h00F2; 8'h96: r = 16'h00FB; 8'h97: r = 16'h00F9;
                8'h98: r = 16'h00FF; 8'h99: r = 16'h00D6; 8'h9A: r = 16'h00DC;
                8'h9B: r = 16'h00A2; 8'h9C: r = 16'h00A3; 8'h9D: r = 16'h00A5;
                8'h9E: r = 16'h20A7; 8'h9F: r = 16'h0192; 8'hA0: r = 16'h00E1;
                8'hA1: r = 16'h00ED; 8'hA2: r = 16'h00F3; 8'hA3: r = 16'h00FA;
                8'hA4: r = 16'h00F1; 8'hA5: r = 16'h00D1; 8'hA6: r = 16'h00AA;
                8'hA7: r = 16'h00BA; 8'hA8: r = 16'h00BF; 8'hA9: r = 16'h2310;
                8'hAA: r = 16'h00AC; 8'hAB: r = 16'h00BD; 8'hAC: r = 16'h00BC;
                8'hAD: r = 16'h00A1; 8'hAE: r = 16'h00AB; 8'hAF: r = 16'h00BB;
                8'hB0: r = 16'h2591; 8'hB1: r = 16'h2592; 8'hB2: r = 16'h2593;
                8'hB3: r = 16'h2502; 8'hB4: r = 16'h2524; 8'hB5: r = 16'h2561;
                8'hB6: r = 16'h2562; 8'hB7: r = 16'h2556; 8'hB8: r = 16'h2555;
                8'hB9: r = 16'h2563; 8'hBA: r = 16'h2551; 8'hBB: r = 16'h2557;
                8'hBC: r = 16'h255D; 8'hBD: r = 16'h255C; 8'hBE: r = 16'h255B;
                8'hBF: r = 16'h2510; 8'hC0: r = 16'h2514; 8'hC1: r = 16'h2534;
                8'hC2: r = 16'h252C; 8'hC3: r = 16'h251C; 8'hC4: r = 16'h2500;
                8'hC5: r = 16'h253C; 8'hC6: r = 16'h255E; 8'hC7: r = 16'h255F;
                8'hC8: r = 16'h255A; 8'hC9: r = 16'h2554; 8'hCA: r = 16'h2569;
                8'hCB: r = 16'h2566; 8'hCC: r = 16'h2560; 8'hCD: r = 16'h2550;
                8'hCE: r = 16'h256C; 8'hCF: r = 16'h2567; 8'hD0: r = 16'h2568;
                8'hD1: r = 16'h2564; 8'hD2: r = 16'h2565; 8'hD3: r = 16'h2559;
                8'hD4: r = 16'h2558; 8'hD5: r = 16'h2552; 8'hD6: r = 16'h2553;
                8'hD7: r = 16'h256B; 8'hD8: r = 16'h256A; 8'hD9: r = 16'h2518;
                8'hDA: r = 16'h250C; 8'hDB: r = 16'h2588; 8'hDC: r = 16'h2584;
                8'hDD: r = 16'h258C; 8'hDE: r = 16'h2590; 8'hDF: r = 16'h2580;
                8'hE0: r = 16'h03B1; 8'hE1: r = 16'h00DF; 8'hE2: r = 16'h0393;
                8'hE3: r = 16'h03C0; 8'hE4: r = 16'h03A3; 8'hE5: r = 16'h03C3;
                8'hE6: r = 16'h00B5; 8'hE7: r = 16'h03C4; 8'hE8: r = 16'h03A6;
                8'hE9: r = 16'h0398; 8'hEA: r = 16'h03A9; 8'hEB: r = 16'h03B4;
                8'hEC: r = 16'h221E; 8'hED: r = 16'h03C6; 8'hEE: r = 16'h03B5;
                8'hEF: r = 16'h2229; 8'hF0: r = 16'h2261; 8'hF1: r = 16'h00B1;
                8'hF2: r = 16'h2265; 8'hF3: r = 16'h2264; 8'hF4: r = 16'h2320;
                8'hF5: r = 16'h2321; 8'hF6: r = 16'h00F7; 8'hF7: r = 16'h2248;
                8'hF8: r = 16'h00B0; 8'hF9: r = 16'h2219; 8'hFA: r = 16'h00B7;
                8'hFB: r = 16'h221A; 8'hFC: r = 16'h207F; 8'hFD: r = 16'h00B2;
                8'hFE: r = 16'h25A0; 8'hFF: r = 16'h00A0;
                default: r = {8'h00, b};
            endcase
            return r;
        end
    endfunction

    // overlay for code page 850, hit flags positions that differ
    function automatic logic [16:0] cp850_patch(input logic [7:0] b);
        logic [16:0] r;
        begin
            r = '0;
            case (b)
                8'h9B: r = {1'b1, 16'h00F8}; 8'h9D: r = {1'b1, 16'h00D8};
                8'h9E: r = {1'b1, 16'h00D7}; 8'hA9: r = {1'b1, 16'h00AE};
                8'hB5: r = {1'b1, 16'h00C1}; 8'hB6: r = {1'b1, 16'h00C2};
                8'hB7: r = {1'b1, 16'h00C0}; 8'hB8: r = {1'b1, 16'h00A9};
                8'hBD: r = {1'b1, 16'h00A2}; 8'hBE: r = {1'b1, 16'h00A5};
                8'hC6: r = {1'b1, 16'h00E3}; 8'hC7: r = {1'b1, 16'h00C3};
                8'hCF: r = {1'b1, 16'h00A4}; 8'hD0: r = {1'b1, 16'h00F0};
                8'hD1: r = {1'b1, 16'h00D0}; 8'hD2: r = {1'b1, 16'h00CA};
                8'hD3: r = {1'b1, 16'h00CB}; 8'hD4: r = {1'b1, 16'h00C8};
                8'hD5: r = {1'b1, 16'h0131}; 8'hD6: r = {1'b1, 16'h00CD};
                8'hD7: r = {1'b1, 16'h00CE}; 8'hD8: r = {1'b1, 16'h00CF};
                8'hDD: r = {1'b1, 16'h00A6}; 8'hDE: r = {1'b1, 16'h00CC};
                8'hE0: r = {1'b1, 16'h00D3}; 8'hE2: r = {1'b1, 16'h00D4};
                8'hE3: r = {1'b1, 16'h00D2}; 8'hE4: r = {1'b1, 16'h00F5};
                8'hE5: r = {1'b1, 16'h00D5}; 8'hE7: r = {1'b1, 16'h00FE};
                8'hE8: r = {1'b1, 16'h00DE}; 8'hE9: r = {1'b1, 16'h00DA};
                8'hEA: r = {1'b1, 16'h00DB}; 8'hEB: r = {1'b1, 16'h00D9};
                8'hEC: r = {1'b1, 16'h00FD}; 8'hED: r = {1'b1, 16'h00DD};
                8'hEE: r = {1'b1, 16'h00AF}; 8'hEF: r = {1'b1, 16'h00B4};
                8'hF0: r = {1'b1, 16'h00AD}; 8'hF2: r = {1'b1, 16'h2017};
                8'hF3: r = {1'b1, 16'h00BE}; 8'hF4: r = {1'b1, 16'h00B6};
                8'hF5: r = {1'b1, 16'h00A7}; 8'hF7: r = {1'b1, 16'h00B8};
                8'hF9: r = {1'b1, 16'h00A8}; 8'hFB: r = {1'b1, 16'h00B9};
                8'hFC: r = {1'b1, 16'h00B3};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/core/cpu8_serializer.sv */
module cpu8_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cpu8_pkg::t_enc  i_enc,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);
    import cpu8_pkg::*;

    logic       r_busy, n_busy;
    t_enc       r_enc, n_enc;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_ov, n_ov;
    logic       take_out, load, step_ok;

    assign take_out = r_ov && i_ready;
    // output register may load when empty or being drained
    assign step_ok  = !r_ov || i_ready;
    // accept a new char when nothing pending or the last byte is moving now
    assign o_ready  = !r_busy || (step_ok && (r_idx == r_enc.cnt - 2'd1));
    assign load     = i_valid && o_ready;

    always_comb begin
        n_busy = r_busy;
        n_enc  = r_enc;
        n_idx  = r_idx;
        n_byte = r_byte;
        n_last = r_last;
        n_ov   = r_ov && !take_out;
        if (r_busy && step_ok) begin
            case (r_idx)
                2'd0:    n_byte = r_enc.b0;
                2'd1:    n_byte = r_enc.b1;
                default: n_byte = r_enc.b2;
            endcase
            n_last = (r_idx == r_enc.cnt - 2'd1);
            n_ov   = 1'b1;
            n_idx  = r_idx + 2'd1;
            if (n_last) begin
                n_busy = 1'b0;
            end
        end
        if (load && i_enc.cnt != CntNone) begin
            n_busy = 1'b1;
            n_enc  = i_enc;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
            r_idx  <= n_idx;
        end
        r_enc  <= n_enc;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_valid = r_ov;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
endmodule

/* rtl/core/codepage_to_utf8_transcoder.sv */
// Maps one DOS byte per item through code page 437 (or 437 with the 850
// overlay when the mode register is 1) and emits its UTF-8 encoding one byte
// per item on the master side, tlast on the final byte; byte 0x00 emits
// nothing, and bytes 0x07 to 0x0D and 0x1B pass as themselves. A three-stage
// pipeline (table lookup, encode, byte serializer) takes a new byte every
// cycle while the sink is ready and each character is one UTF-8 byte; the
// serializer's one-byte-per-cycle output holds input back on longer ones.
module codepage_to_utf8_transcoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // source_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // utf8_byte
    output logic       m_axis_tlast,   // last_of_char
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_data        // code_page_select
);
    import cpu8_pkg::*;

    logic r_sel;
    logic r_v1, r_v2;
    t_cp  r_cp;
    t_enc r_enc;
    t_cp  n_cp;
    t_enc n_enc;
    logic adv1, adv2, ser_ready;
    logic [16:0] patch;

    assign cfg_ready = 1'b1;

    // stage 2 advances into serializer; stage 1 into stage 2
    assign adv2 = !r_v2 || ser_ready;
    assign adv1 = !r_v1 || adv2;
    assign s_axis_tready = adv1;

    always_comb begin
        patch = cp850_patch(s_axis_tdata);
        n_cp  = cp437_lookup(s_axis_tdata);
        if (r_sel && patch[16]) begin
            n_cp = patch[15:0];
        end
        if ((s_axis_tdata >= 8'h07 && s_axis_tdata <= 8'h0D) || s_axis_tdata == 8'h1B) begin
            n_cp = {8'h00, s_axis_tdata};
        end
    end

    always_comb begin
        n_enc = '0;
        if (r_cp == 16'h0000) begin
            n_enc.cnt = CntNone;
        end else if (r_cp <= 16'h007F) begin
            n_enc.cnt = CntOne;
            n_enc.b0  = {1'b0, r_cp[6:0]};
        end else if (r_cp <= 16'h07FF) begin
            n_enc.cnt = CntTwo;
            n_enc.b0  = {3'b110, r_cp[10:6]};
            n_enc.b1  = {2'b10, r_cp[5:0]};
        end else begin
            n_enc.cnt = CntThree;
            n_enc.b0  = {4'b1110, r_cp[15:12]};
            n_enc.b1  = {2'b10, r_cp[11:6]};
            n_enc.b2  = {2'b10, r_cp[5:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                r_sel <= cfg_data[0];
            end
            if (adv1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
        if (adv1) begin
            r_cp <= n_cp;
        end
        if (adv2) begin
            r_enc <= n_enc;
        end
    end

    cpu8_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .o_ready (ser_ready),
        .i_enc   (r_enc),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );
endmodule

/* rtl/core/cpu8_checker.sv */
module cpu8_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    // a lead byte of a multibyte char is never last
    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7:6] == 2'b11 |-> !m_axis_tlast)
        else $error("lead byte flagged last");
    // a continuation byte follows a non-last byte
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        !m_axis_tvalid || m_axis_tdata[7:6] == 2'b10)
        else $error("bad continuation");
    // ascii bytes are always single
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tlast)
        else $error("ascii not last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped under stall");
    // reset clears output valid
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output after reset");
endmodule

bind codepage_to_utf8_transcoder cpu8_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // source_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // utf8_byte
    logic       m_axis_tlast;   // last_of_char
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_data;       // code_page_select

    codepage_to_utf8_transcoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_char;
    } utf8_out_t;

    function automatic logic [15:0] cp437_point(logic [7:0] b);
        logic [15:0] t [0:255];
        t = '{
            16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
            16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
            16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
            16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC,
            16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
            16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
            16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
            16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
            16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
            16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
            16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
            16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h005F,
            16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
            16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
            16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
            16'h0078, 16'h0079, 16'h007A, 16'h007B, 16'h007C, 16'h007D, 16'h007E, 16'h2302,
            16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
            16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
            16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
            16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
            16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
            16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
            16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
            16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
            16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
            16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
            16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
            16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
            16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
            16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
            16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
            16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
        };
        return t[b];
    endfunction

    function automatic logic [15:0] cp850_point(logic [7:0] b, logic [15:0] dflt);
        logic [23:0] p [0:46];
        p = '{
            24'h9B00F8, 24'h9D00D8, 24'h9E00D7, 24'hA900AE, 24'hB500C1, 24'hB600C2,
            24'hB700C0, 24'hB800A9, 24'hBD00A2, 24'hBE00A5, 24'hC600E3, 24'hC700C3,
            24'hCF00A4, 24'hD000F0, 24'hD100D0, 24'hD200CA, 24'hD300CB, 24'hD400C8,
            24'hD50131, 24'hD600CD, 24'hD700CE, 24'hD800CF, 24'hDD00A6, 24'hDE00CC,
            24'hE000D3, 24'hE200D4, 24'hE300D2, 24'hE400F5, 24'hE500D5, 24'hE700FE,
            24'hE800DE, 24'hE900DA, 24'hEA00DB, 24'hEB00D9, 24'hEC00FD, 24'hED00DD,
            24'hEE00AF, 24'hEF00B4, 24'hF000AD, 24'hF22017, 24'hF300BE, 24'hF400B6,
            24'hF500A7, 24'hF700B8, 24'hF900A8, 24'hFB00B9, 24'hFC00B3
        };
        foreach (p[k])
            if (p[k][23:16] == b) return p[k][15:0];
        return dflt;
    endfunction

    class utf8_scoreboard;
        utf8_out_t  pending[$];
        bit         use_cp850;
        int         errors;

        function logic [15:0] code_point(logic [7:0] b);
            logic [15:0] cp;
            cp = cp437_point(b);
            if (use_cp850) cp = cp850_point(b, cp);
            if ((b >= 8'h07 && b <= 8'h0D) || b == 8'h1B) cp = {8'h00, b};
            return cp;
        endfunction

        function void note_source(logic [7:0] b);
            logic [15:0] cp;
            cp = code_point(b);
            if (cp == 16'h0000) begin
                // nul maps to nothing
            end else if (cp <= 16'h007F) begin
                pending.push_back({cp[7:0], 1'b1});
            end else if (cp <= 16'h07FF) begin
                pending.push_back({3'b110, cp[10:6], 1'b0});
                pending.push_back({2'b10, cp[5:0], 1'b1});
            end else begin
                pending.push_back({4'b1110, cp[15:12], 1'b0});
                pending.push_back({2'b10, cp[11:6], 1'b0});
                pending.push_back({2'b10, cp[5:0], 1'b1});
            end
        endfunction

        function void check_byte(logic [7:0] d, logic l);
            utf8_out_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0d", $time, d, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.utf8_byte !== d || e.last_of_char !== l) begin
                $display("%0t: expected %02h last %0d, got %02h last %0d",
                         $time, e.utf8_byte, e.last_of_char, d, l);
                errors++;
            end
        endfunction
    endclass

    utf8_scoreboard sb;
    int unsigned    cycle_cnt;
    int unsigned    src_idle_pct;
    int unsigned    sink_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > 200000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // output sink: random stall, check on every accepted byte
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_byte(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // valid stays high after an accepted item until the next idle or drain
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_source(b);
    endtask

    task automatic drain_and_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // pipeline may still hold a nul item
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_code_page(input bit sel);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.use_cp850 = sel;
    endtask

    task automatic random_burst(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: b = 8'h80 + 8'($urandom_range(127));
                1: b = 8'h00 + 8'($urandom_range(31));
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b);
        end
    endtask

    initial begin
        logic [7:0] directed [0:19];
        sb = new();
        directed = '{8'h00, 8'h01, 8'h07, 8'h0D, 8'h0E, 8'h1B, 8'h20, 8'h41, 8'h7E,
                     8'h7F, 8'h80, 8'h9B, 8'hA9, 8'hD5, 8'hF2, 8'hFC, 8'hFD, 8'hFF,
                     8'h55, 8'hAA};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        src_idle_pct  = 14;
        sink_idle_pct = 59;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed bytes in reset mode, then in the 850 overlay mode
        foreach (directed[i]) send_byte(directed[i]);
        drain_and_idle();
        write_code_page(1'b1);
        foreach (directed[i]) send_byte(directed[i]);
        drain_and_idle();
        write_code_page(1'b0);
        random_burst(60);
        drain_and_idle();

        src_idle_pct  = 59;
        sink_idle_pct = 14;
        write_code_page(1'b1);
        random_burst(110);
        drain_and_idle();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_code_page(1'b0);
        random_burst(80);
        drain_and_idle();
        write_code_page(1'b1);
        random_burst(80);
        drain_and_idle();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cpu8_pkg.sv
rtl/core/cpu8_serializer.sv
rtl/core/codepage_to_utf8_transcoder.sv
rtl/core/cpu8_checker.sv
tb/sv/tb.sv
